[rtl/dip_pkg.sv]
// Package for the decimal integer parser: character constants, character
// classes, the queue entry type and the parser phase encoding. No dependencies.
package dip_pkg;

  localparam int OUT_WIDTH   = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int DIGIT_MAX   = 9;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = CH_ZERO + 8'(DIGIT_MAX);

  typedef enum logic [2:0] {
    CL_TERM,
    CL_SPACE,
    CL_MINUS,
    CL_DIGIT,
    CL_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } entry_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL,
    PH_ERROR
  } phase_t;

endpackage

[rtl/dip_front.sv]
// Front end of the decimal integer parser: classifies one input character.
// Depends on dip_pkg.
module dip_front (
  input  logic [7:0]      char_code,
  output dip_pkg::entry_t entry
);
  import dip_pkg::*;

  always_comb begin
    entry.digit = 4'd0;
    if (char_code == CH_NUL) begin
      entry.cls = CL_TERM;
    end else if (char_code inside {CH_SPACE, CH_LF, CH_TAB, CH_CR, CH_VT, CH_FF}) begin
      entry.cls = CL_SPACE;
    end else if (char_code == CH_MINUS) begin
      entry.cls = CL_MINUS;
    end else if (char_code inside {[CH_ZERO:CH_NINE]}) begin
      entry.cls   = CL_DIGIT;
      entry.digit = 4'(char_code - CH_ZERO);
    end else begin
      entry.cls = CL_OTHER;
    end
  end

endmodule

[rtl/dip_queue.sv]
// Short register queue between the classifier and the parser back end.
// Depends on dip_pkg.
module dip_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dip_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output dip_pkg::entry_t head
);
  import dip_pkg::*;

  entry_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;

  assign full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/dip_back.sv]
// Back end of the decimal integer parser: phase machine, accumulator and the
// result register. Depends on dip_pkg.
module dip_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ent_valid,
  input  dip_pkg::entry_t                 ent,
  output logic                            ent_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [dip_pkg::OUT_WIDTH-1:0] out_value,
  output logic                            out_bad_literal
);
  import dip_pkg::*;

  phase_t                        phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0]        acc_r, acc_nxt;
  logic                          neg_r, neg_nxt;
  logic                          out_valid_r;
  logic signed [OUT_WIDTH-1:0]   out_value_r, value_nxt;
  logic                          out_bad_r, bad_nxt;
  logic                          is_term;
  logic [VALUE_WIDTH-1:0]        mag;
  logic signed [VALUE_WIDTH-1:0] res_s;

  assign is_term = (ent.cls == CL_TERM);
  // A terminator needs the result register free; other characters never stall.
  assign ent_pop = ent_valid && (!is_term || !out_valid_r || out_ready);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (ent_pop) begin
      case (phase_r)
        PH_LEAD: begin
          case (ent.cls)
            CL_TERM:  phase_nxt = PH_LEAD;
            CL_SPACE: phase_nxt = PH_LEAD;
            CL_MINUS: phase_nxt = PH_SIGN;
            CL_DIGIT: phase_nxt = PH_DIGITS;
            default:  phase_nxt = PH_ERROR;
          endcase
        end
        PH_SIGN, PH_DIGITS: begin
          case (ent.cls)
            CL_TERM:  phase_nxt = PH_LEAD;
            CL_SPACE: phase_nxt = PH_TRAIL;
            CL_DIGIT: phase_nxt = PH_DIGITS;
            default:  phase_nxt = PH_ERROR;
          endcase
        end
        PH_TRAIL: begin
          case (ent.cls)
            CL_TERM:  phase_nxt = PH_LEAD;
            CL_SPACE: phase_nxt = PH_TRAIL;
            default:  phase_nxt = PH_ERROR;
          endcase
        end
        default: begin
          phase_nxt = is_term ? PH_LEAD : PH_ERROR;
        end
      endcase
    end
  end

  // Accumulator, sign and result.
  always_comb begin
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    bad_nxt   = !(phase_r == PH_DIGITS || phase_r == PH_TRAIL);
    mag       = neg_r ? ('0 - acc_r) : acc_r;
    res_s     = bad_nxt ? '0 : $signed(mag);
    value_nxt = OUT_WIDTH'(res_s);
    if (is_term) begin
      acc_nxt = '0;
      neg_nxt = 1'b0;
    end else if (ent.cls == CL_DIGIT) begin
      if (phase_r == PH_LEAD || phase_r == PH_SIGN) begin
        acc_nxt = VALUE_WIDTH'(ent.digit);
      end else if (phase_r == PH_DIGITS) begin
        // Times ten as two shifts, plus the digit.
        acc_nxt = (acc_r << 3) + (acc_r << 1) + VALUE_WIDTH'(ent.digit);
      end
    end else if (ent.cls == CL_MINUS && phase_r == PH_LEAD) begin
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (ent_pop) begin
        acc_r <= acc_nxt;
        neg_r <= neg_nxt;
      end
      if (ent_pop && is_term) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_pop && is_term) begin
      out_value_r <= value_nxt;
      out_bad_r   <= bad_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_bad_literal = out_bad_r;

endmodule

[rtl/decimal_integer_parser.sv]
// Top level of the decimal integer parser: classifier, queue and back end.
// Depends on dip_pkg, dip_front, dip_queue and dip_back.
//
// Usage: characters arrive on the in_ channel, one per request, and a zero
// character ends a string. Leading whitespace, one optional minus sign,
// decimal digits and trailing whitespace form a valid literal. On the
// terminator one result leaves on the out_ channel: the signed value,
// wrapped to VALUE_WIDTH bits and sign-extended to 64, or out_bad_literal
// set with a zero value. Other characters give no result.
// Throughput is one character per cycle while in_ready is high. A
// terminator is first written into the two-entry queue, and the back end
// then pops it and loads the result register, which drives out_valid.
// When the receiver stalls, the result register holds its request; the back
// end keeps taking characters until it meets the next terminator, and the
// queue then fills and in_ready drops.
// Synchronous reset empties the queue, drops any pending result and
// returns the parser to the leading-whitespace phase with a zero value.
module decimal_integer_parser #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_char_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dip_pkg::OUT_WIDTH-1:0] out_value,
  output logic                                 out_bad_literal
);
  import dip_pkg::*;

  entry_t cls_entry;
  entry_t head;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  assign in_ready = !q_full;

  dip_front u_front (
    .char_code (in_char_code),
    .entry     (cls_entry)
  );

  dip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_data (cls_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  dip_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .ent_valid       (!q_empty),
    .ent             (head),
    .ent_pop         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_bad_literal (out_bad_literal)
  );

endmodule

[rtl/dip_checker.sv]
// Port-level checks for the decimal integer parser, bound to its top level.
// Depends on dip_pkg and decimal_integer_parser.
module dip_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [dip_pkg::OUT_WIDTH-1:0] out_value,
  input logic                                 out_bad_literal
);
  import dip_pkg::*;

  // After reset the queue is empty and no result is pending.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pending state after reset");

  // An error result always carries a zero value.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_literal) |-> (out_value == '0))
    else $error("error result with nonzero value");

  // A stalled result stays.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_value) && $stable(out_bad_literal)))
    else $error("result changed while stalled");

endmodule

bind decimal_integer_parser dip_checker u_dip_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_value       (out_value),
  .out_bad_literal (out_bad_literal)
);
